/* rtl/tprm_pkg.sv */
// shared types and constants of the tooth period tachometer
`timescale 1ns / 1ps

package tprm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUMERATOR = 4'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'hffff;
    localparam logic [31:0] NUMER_RESET   = 32'd6666666;

    // field widths
    localparam int PERIOD_W = 16;
    localparam int SPEED_W  = 16;
    localparam int NUMER_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hffff;

    // stream words
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_DIV1 = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_DIV2 = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

endpackage

/* rtl/tooth_period_rpm_meter.sv */
// tooth period tachometer: tick counter, period ring and bit-serial speed divider
//
//  channel   dir  handshake               word
//  s_axis    in   tvalid / tready         tdata[0] tooth_edge
//  m_axis    out  tvalid / tready         tdata speed_rpm, tooth_period; tuser stopped
//  cfg       in   valid / ready (always)  index, data
//
// a tick without an edge is handled in idle; an edge tick updates the running sum
// and, unless the period or average is zero, runs the shared restoring divider that
// retires one quotient bit per cycle (average of the ring first, then numerator over average).
// reset is synchronous, active low; the ring reads as zero through per-slot
// valid flops cleared at once, so no clearing pass is needed.
// a result waits in the output register; a new tick is taken while it is
// being taken in the same cycle.
`timescale 1ns / 1ps

module tooth_period_rpm_meter #(
    parameter int WINDOW = 36
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tooth_edge in bit 0, zero padded
    input  logic [tprm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // speed_rpm [15:0], tooth_period [31:16]
    output logic [tprm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // stopped
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tprm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tprm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tprm_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [PERIOD_W-1:0] WINDOW_DIV = PERIOD_W'(WINDOW);

    // configuration registers
    logic [PERIOD_W-1:0] r_timeout;
    logic [NUMER_W-1:0]  r_numer;

    // measurement state
    t_state              r_state, n_state;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_counting, n_counting;
    logic [PERIOD_W-1:0] r_last, n_last;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SPEED_W-1:0]  r_speed, n_speed;

    // ring storage and its registered read
    logic [PERIOD_W-1:0] r_ring [WINDOW];
    logic [WINDOW-1:0]   r_ring_vld;
    logic [PERIOD_W-1:0] r_old;
    logic                r_old_vld;

    // serial divider
    logic [NUMER_W-1:0]  r_quo, n_quo;
    logic [PERIOD_W-1:0] r_rem, n_rem;
    logic [PERIOD_W-1:0] r_div, n_div;
    logic [4:0]          r_cnt, n_cnt;

    // output register
    logic                r_out_vld, n_out_vld;
    logic [SPEED_W-1:0]  r_out_speed, n_out_speed;
    logic [PERIOD_W-1:0] r_out_period, n_out_period;
    logic                r_out_stop, n_out_stop;

    logic                w_in_acc;
    logic                w_edge;
    logic [PERIOD_W-1:0] w_tick_inc;
    logic [PERIOD_W:0]   w_trial;
    logic                w_ge;
    logic [PERIOD_W-1:0] w_rem_step;
    logic [NUMER_W-1:0]  w_quo_step;
    logic [PERIOD_W-1:0] w_old;
    logic                w_out_free;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_edge        = s_axis_tdata[0];
    assign w_tick_inc    = r_tick + 1'b1;
    assign w_old         = r_old_vld ? r_old : '0;

    // one restoring step: bring down the next dividend bit
    assign w_trial    = {r_rem, r_quo[NUMER_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_div};
    assign w_rem_step = w_ge ? PERIOD_W'(w_trial - {1'b0, r_div}) : w_trial[PERIOD_W-1:0];
    assign w_quo_step = {r_quo[NUMER_W-2:0], w_ge};

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_period, r_out_speed};
    assign m_axis_tuser  = r_out_stop;

    // next state of the sequencer and datapath
    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_counting   = r_counting;
        n_last       = r_last;
        n_slot       = r_slot;
        n_sum        = r_sum;
        n_speed      = r_speed;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_cnt        = r_cnt;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_speed  = r_out_speed;
        n_out_period = r_out_period;
        n_out_stop   = r_out_stop;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_edge) begin
                        n_last     = r_tick;
                        n_tick     = '0;
                        n_counting = 1'b1;
                        n_state    = ST_SUM;
                    end else if (r_counting) begin
                        if (w_tick_inc >= r_timeout) begin
                            n_counting   = 1'b0;
                            n_tick       = '0;
                            n_last       = '0;
                            n_out_vld    = 1'b1;
                            n_out_speed  = '0;
                            n_out_period = '0;
                            n_out_stop   = 1'b1;
                        end else begin
                            n_tick = w_tick_inc;
                        end
                    end
                end
            end
            // update running sum, start average division unless the period is zero
            ST_SUM: begin
                n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_last);
                n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                n_quo  = {{(NUMER_W-SUM_W){1'b0}}, n_sum};
                n_rem  = '0;
                n_div  = WINDOW_DIV;
                n_cnt  = '0;
                if (r_last == '0) begin
                    n_speed = '0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                n_quo = w_quo_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_CHK;
                end
            end
            // average zero saturates, else divide numerator by it
            ST_CHK: begin
                if (r_quo[PERIOD_W-1:0] == '0) begin
                    n_speed = SPEED_MAX;
                    n_state = ST_DONE;
                end else begin
                    n_div   = r_quo[PERIOD_W-1:0];
                    n_quo   = r_numer;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                n_quo = w_quo_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_speed = (|w_quo_step[NUMER_W-1:SPEED_W]) ? SPEED_MAX
                                                               : w_quo_step[SPEED_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_speed  = r_speed;
                    n_out_period = r_last;
                    n_out_stop   = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tick     <= '0;
            r_counting <= 1'b1;
            r_last     <= '0;
            r_slot     <= '0;
            r_sum      <= '0;
            r_out_vld  <= 1'b0;
            r_timeout  <= TIMEOUT_RESET;
            r_numer    <= NUMER_RESET;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_counting <= n_counting;
            r_last     <= n_last;
            r_slot     <= n_slot;
            r_sum      <= n_sum;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT_TICKS:   r_timeout <= i_cfg_data[PERIOD_W-1:0];
                    CFG_SPEED_NUMERATOR: r_numer   <= i_cfg_data[NUMER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_speed      <= n_speed;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_cnt        <= n_cnt;
        r_out_speed  <= n_out_speed;
        r_out_period <= n_out_period;
        r_out_stop   <= n_out_stop;
    end

    // period ring: read the old slot on an edge, write the new period after
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_edge) begin
            r_old <= r_ring[r_slot];
        end
        if (r_state == ST_SUM) begin
            r_ring[r_slot] <= r_last;
        end
    end

    // slot valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_old_vld  <= 1'b0;
        end else begin
            if (w_in_acc && w_edge) begin
                r_old_vld <= r_ring_vld[r_slot];
            end
            if (r_state == ST_SUM) begin
                r_ring_vld[r_slot] <= 1'b1;
            end
        end
    end

endmodule

/* tb/tooth_period_rpm_meter_tb.sv */
// self-checking testbench of the tooth period tachometer
`timescale 1ns / 1ps

module tooth_period_rpm_meter_tb;

    import tprm_pkg::*;

    localparam int WINDOW  = 36;
    // an edge tick runs two 32-bit divisions plus the sum, check and done states
    localparam int LATENCY = 2 * 32 + 4;

    // one result word split into its fields
    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [PERIOD_W-1:0] period;
        logic                stopped;
    } t_rpm_word;

    // tachometer predictor and queue of awaited result words
    class t_rpm_scoreboard;
        logic [15:0]         timeout_ticks;
        logic [NUMER_W-1:0]  numerator;
        logic [15:0]         tick_count;
        logic                counting;
        logic [PERIOD_W-1:0] last_period;
        logic [PERIOD_W-1:0] ring [WINDOW];
        int unsigned         slot;
        logic [21:0]         period_sum;
        t_rpm_word           awaited [$];
        int                  n_words;
        int                  n_ticks;
        int                  n_edges;
        int                  n_stops;
        int                  n_checked;
        int                  n_errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            numerator     = NUMER_RESET;
            tick_count    = '0;
            counting      = 1'b1;
            last_period   = '0;
            foreach (ring[i]) ring[i] = '0;
            slot       = 0;
            period_sum = '0;
            n_words    = 0;
            n_ticks    = 0;
            n_edges    = 0;
            n_stops    = 0;
            n_checked  = 0;
            n_errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TIMEOUT_TICKS) begin
                timeout_ticks = data[15:0];
            end else if (idx == CFG_SPEED_NUMERATOR) begin
                numerator = data;
            end
        endfunction

        // advance the model by one accepted tick word
        function void note_tick(logic tooth);
            t_rpm_word   w;
            logic [21:0] avg;
            logic [31:0] quo;
            n_words++;
            if (tooth) begin
                last_period = tick_count;
                period_sum  = period_sum - ring[slot] + last_period;
                ring[slot]  = last_period;
                slot        = (slot == WINDOW - 1) ? 0 : slot + 1;
                tick_count  = '0;
                counting    = 1'b1;
                w.stopped   = 1'b0;
                w.period    = last_period;
                if (last_period == '0) begin
                    w.speed = '0;
                end else begin
                    avg = 22'(period_sum / WINDOW);
                    if (avg == '0) begin
                        w.speed = SPEED_MAX;
                    end else begin
                        quo     = numerator / avg;
                        w.speed = (quo > 32'h0000_ffff) ? SPEED_MAX : quo[15:0];
                    end
                end
                awaited.push_back(w);
                n_ticks++;
                n_edges++;
            end else if (counting) begin
                n_ticks++;
                tick_count = tick_count + 16'd1;
                // a zero timeout behaves as one since the count is at least one here
                if (tick_count >= timeout_ticks) begin
                    counting    = 1'b0;
                    tick_count  = '0;
                    last_period = '0;
                    w.speed     = '0;
                    w.period    = '0;
                    w.stopped   = 1'b1;
                    awaited.push_back(w);
                    n_stops++;
                end
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check(t_rpm_word got);
            t_rpm_word want;
            n_checked++;
            if (awaited.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word: speed %0d period %0d stopped %0b",
                             got.speed, got.period, got.stopped);
                return;
            end
            want = awaited.pop_front();
            if (got.speed != want.speed || got.period != want.period ||
                got.stopped != want.stopped) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("word %0d: speed %0d/%0d period %0d/%0d stopped %0b/%0b (exp/act)",
                             n_checked, want.speed, got.speed, want.period, got.period,
                             want.stopped, got.stopped);
            end
        endfunction

        // words still awaited at the end count as failures
        function void close_out();
            if (awaited.size() != 0) begin
                if (n_errors < 10)
                    $display("%0d words never arrived", awaited.size());
                n_errors += awaited.size();
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_rpm_scoreboard sb = new();
    bit              quiet_tx = 1'b0;
    bit              quiet_rx = 1'b0;
    int              rx_stall = 0;

    tooth_period_rpm_meter #(
        .WINDOW(WINDOW)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side: random stalls on tready
    always @(negedge i_clk) begin
        if (quiet_rx) begin
            m_axis_tready = 1'b1;
        end else if (rx_stall > 0) begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready = 1'b1;
            rx_stall = pick_gap();
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser});
    end

    // send one tick word, starting and ending at a falling edge
    task automatic send_tick(input logic tooth);
        int gap;
        gap = quiet_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(S_TDATA_W-1){1'b0}}, tooth};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(tooth);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait until every awaited word is out and the divider is quiet
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int            phase;
        int            phase_end;
        int            rand_words0;
        int            lim;
        int            cap;
        int            p;
        logic [15:0]   to_val;
        logic [31:0]   num_val;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // edge straight after reset: period zero gives speed zero
        send_tick(1'b1);
        // short first period: average truncates to zero, speed saturates
        repeat (5) send_tick(1'b0);
        send_tick(1'b1);
        // back-to-back edges
        send_tick(1'b1);

        // zero timeout stops on the first counted tick
        settle();
        write_cfg(CFG_TIMEOUT_TICKS, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // widest numerator
        settle();
        write_cfg(CFG_TIMEOUT_TICKS, 32'd3);
        write_cfg(CFG_SPEED_NUMERATOR, 32'hffff_ffff);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // long period under the largest timeout
        settle();
        write_cfg(CFG_TIMEOUT_TICKS, 32'h0000_ffff);
        write_cfg(CFG_SPEED_NUMERATOR, NUMER_RESET);
        quiet_tx = 1'b1;
        send_tick(1'b1);
        repeat (100) send_tick(1'b0);
        quiet_tx = 1'b0;
        send_tick(1'b1);

        // smallest numerator: quotient truncates to zero on a nonzero period
        settle();
        write_cfg(CFG_SPEED_NUMERATOR, 32'd1);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);

        // random phases, each with its own register setting
        rand_words0 = sb.n_words;
        phase = 0;
        while (sb.n_words - rand_words0 < 850) begin
            case (phase)
                0: begin
                    to_val  = 16'd1;
                    num_val = 32'hffff_ffff;
                end
                1: begin
                    to_val  = 16'hffff;
                    num_val = 32'd1;
                end
                2: begin
                    to_val  = 16'd2;
                    num_val = $urandom();
                end
                default: begin
                    to_val  = ($urandom_range(0, 5) == 0) ? 16'hffff
                                                          : 16'($urandom_range(3, 60));
                    num_val = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h000f_ffff)
                                                          : $urandom();
                end
            endcase
            settle();
            write_cfg(CFG_TIMEOUT_TICKS, {16'd0, to_val});
            write_cfg(CFG_SPEED_NUMERATOR, num_val);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            lim = (to_val == 16'd0) ? 1 : int'(to_val);
            cap = (lim > 40) ? 40 : lim;
            phase_end = sb.n_words + 140;
            while (sb.n_words < phase_end) begin
                if ($urandom_range(0, 99) < 80) begin
                    // a tooth period, sometimes long enough to time out first
                    if ($urandom_range(0, 9) < 7)
                        p = $urandom_range(0, cap - 1);
                    else
                        p = cap + $urandom_range(0, 3);
                    repeat (p) send_tick(1'b0);
                    send_tick(1'b1);
                end else begin
                    // noise: random edge bits
                    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;

        // drain and finish
        settle();
        sb.close_out();
        $display("run covered %0d tick words: %0d counted, %0d tooth edges, %0d timeout stops",
                 sb.n_words, sb.n_ticks, sb.n_edges, sb.n_stops);
        $display("%0d random register settings, %0d result words checked",
                 phase, sb.n_checked);
        if (sb.n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("timeout: stimulus or results stalled");
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tprm_pkg.sv
rtl/tooth_period_rpm_meter.sv
tb/tooth_period_rpm_meter_tb.sv
